// File: rtl/rpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpp_pkg;

    // Default sizing, handed to the top level parameters
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int BUCKET_BITS_DEF  = 8;

    // Fixed field widths
    localparam int OPCODE_W     = 1;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 1;
    localparam int ITEM_IDX_W   = 12;
    localparam int POS_W        = 13;
    localparam int RADIX_BITS_W = 4;
    localparam int SHIFT_W      = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REQUEST = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_BUCKET  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_ELEMENT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_BITS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'b1;

    // Register reset values
    localparam logic [RADIX_BITS_W-1:0] RADIX_BITS_RST = 4'd9;
    localparam logic [SHIFT_W-1:0]      SHIFT_RST      = 5'd0;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_BUCKETS,
        PH_ELEMENTS,
        PH_DONE
    } t_phase;

    // Controller to datapath
    typedef struct packed {
        logic load_start;   // load accepted: latch bucket, read its count
        logic load_commit;  // count update and element store write
        logic scan_read;    // prefix sum: read one count
        logic scan_write;   // prefix sum: write running sum
        logic bkt_read;     // bucket request accepted: read start
        logic bkt_emit;     // present bucket start
        logic elem_read;    // element request accepted: read its bucket
        logic elem_lookup;  // read the bucket's next slot
        logic elem_emit;    // present element position, bump slot
        logic elem_skip;    // nothing left to drain: close out
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_phase phase;
        logic   fin;          // latched final mark of current load
        logic   scan_last;    // prefix sum at last bucket
        logic   elem_pending; // an element position is left to drain
        logic   out_free;     // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/rpp_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpp_item_if;
    import rpp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  value;
    logic                       final_load;

    modport source (output valid, opcode, value, final_load, input ready);
    modport sink   (input valid, opcode, value, final_load, output ready);
endinterface

`default_nettype wire

// File: rtl/rpp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpp_result_if;
    import rpp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [ITEM_IDX_W-1:0] item_index;
    logic [POS_W-1:0]      position;
    logic                  final_result;
    logic                  overflowed;

    modport source (output valid, kind, item_index, position, final_result, overflowed,
                    input ready);
    modport sink   (input valid, kind, item_index, position, final_result, overflowed,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/rpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rpp_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [rpp_pkg::OPCODE_W-1:0] i_opcode,
    output logic                              o_in_ready,
    input  wire rpp_pkg::t_stat               i_stat,
    output rpp_pkg::t_cmd                     o_cmd
);
    import rpp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_WR,
        S_BKT,
        S_ELEM_LK,
        S_ELEM_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_opcode == OP_LOAD) begin
                        o_cmd.load_start = 1'b1;
                        n_state          = S_LOAD;
                    end else if (i_stat.phase == PH_BUCKETS) begin
                        o_cmd.bkt_read = 1'b1;
                        n_state        = S_BKT;
                    end else if (i_stat.phase == PH_ELEMENTS && i_stat.elem_pending) begin
                        o_cmd.elem_read = 1'b1;
                        n_state         = S_ELEM_LK;
                    end else if (i_stat.phase == PH_ELEMENTS) begin
                        o_cmd.elem_skip = 1'b1;
                    end else begin
                        // request while loading or after the set: dropped
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_commit = 1'b1;
                n_state           = i_stat.fin ? S_SCAN_RD : S_IDLE;
            end
            S_SCAN_RD: begin
                o_cmd.scan_read = 1'b1;
                n_state         = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                o_cmd.scan_write = 1'b1;
                n_state          = i_stat.scan_last ? S_IDLE : S_SCAN_RD;
            end
            S_BKT: begin
                if (i_stat.out_free) begin
                    o_cmd.bkt_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ELEM_LK: begin
                o_cmd.elem_lookup = 1'b1;
                n_state           = S_ELEM_OUT;
            end
            S_ELEM_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.elem_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rpp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rpp_dp #(
    parameter int MAX_ELEMENTS = rpp_pkg::MAX_ELEMENTS_DEF,
    parameter int BUCKET_BITS  = rpp_pkg::BUCKET_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input payload
    input  wire logic signed [rpp_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                                i_final_load,
    // result channel
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [rpp_pkg::KIND_W-1:0]               o_kind,
    output logic [rpp_pkg::ITEM_IDX_W-1:0]           o_item_index,
    output logic [rpp_pkg::POS_W-1:0]                o_position,
    output logic                                     o_final_result,
    output logic                                     o_overflowed,
    // controller
    input  wire rpp_pkg::t_cmd                       i_cmd,
    output rpp_pkg::t_stat                           o_stat
);
    import rpp_pkg::*;

    localparam int NB  = 1 << BUCKET_BITS;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int EAW = $clog2(MAX_ELEMENTS);
    localparam int DW  = (CW > BUCKET_BITS) ? CW : BUCKET_BITS;
    localparam int ABW = $clog2(BUCKET_BITS + 1);

    // configuration and set state
    logic [RADIX_BITS_W-1:0] r_radix_bits;
    logic [SHIFT_W-1:0]      r_shift;
    logic [ABW-1:0]          r_act_bits;
    t_phase                  r_phase;
    logic [CW-1:0]           r_total;
    logic                    r_ovf;
    logic [DW-1:0]           r_drain;
    logic [NB-1:0]           r_cnt_vld;
    logic                    r_out_valid;

    // working registers
    logic [BUCKET_BITS-1:0]  r_bucket;
    logic                    r_fin;
    logic [BUCKET_BITS-1:0]  r_scan_idx;
    logic [CW-1:0]           r_sum;
    logic [CW-1:0]           r_cnt_rd;
    logic                    r_rd_vld;
    logic [BUCKET_BITS-1:0]  r_elem_rd;
    logic [KIND_W-1:0]       r_out_kind;
    logic [ITEM_IDX_W-1:0]   r_out_idx;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_fin;
    logic                    r_out_ovf;

    // stores
    logic [CW-1:0]           cnt_mem  [NB];
    logic [BUCKET_BITS-1:0]  elem_mem [MAX_ELEMENTS];

    logic [RADIX_BITS_W-1:0] ab_raw;
    logic [ABW-1:0]          act_bits;
    logic [BUCKET_BITS-1:0]  bkt_mask;
    logic signed [VALUE_W-1:0] shifted;
    logic [BUCKET_BITS-1:0]  in_bucket;
    logic                    clr;
    logic                    room;
    logic [CW-1:0]           cnt_eff;
    logic                    cnt_re;
    logic [BUCKET_BITS-1:0]  cnt_raddr;
    logic                    cnt_we;
    logic [BUCKET_BITS-1:0]  cnt_waddr;
    logic [CW-1:0]           cnt_wdata;
    logic                    elem_we;
    logic                    bkt_last;
    logic                    elem_last;
    logic [31:0]             drain_ext;
    logic [31:0]             cnt_ext;

    // active bucket bits: setting minus one, saturated
    always_comb begin
        ab_raw = (r_radix_bits == '0) ? '0 : r_radix_bits - RADIX_BITS_W'(1);
        if (32'(ab_raw) > BUCKET_BITS) begin
            act_bits = ABW'(BUCKET_BITS);
        end else begin
            act_bits = ABW'(ab_raw);
        end
        for (int k = 0; k < BUCKET_BITS; k++) begin
            bkt_mask[k] = (32'(act_bits) > k);
        end
    end

    assign shifted   = i_value >>> r_shift;
    assign in_bucket = shifted[BUCKET_BITS-1:0] & bkt_mask;

    assign clr       = i_cmd.load_start && (r_phase != PH_LOAD);
    assign room      = 32'(r_total) < MAX_ELEMENTS;
    assign cnt_eff   = r_rd_vld ? r_cnt_rd : '0;
    assign drain_ext = 32'(r_drain);
    assign cnt_ext   = 32'(cnt_eff);
    assign bkt_last  = (drain_ext + 32'd1) >= (32'd1 << r_act_bits);
    assign elem_last = (drain_ext + 32'd1) >= 32'(r_total);

    // count store port selection
    always_comb begin
        cnt_re    = 1'b1;
        cnt_raddr = r_elem_rd;
        priority if (i_cmd.load_start) begin
            cnt_raddr = in_bucket;
        end else if (i_cmd.scan_read) begin
            cnt_raddr = r_scan_idx;
        end else if (i_cmd.bkt_read) begin
            cnt_raddr = r_drain[BUCKET_BITS-1:0];
        end else if (i_cmd.elem_lookup) begin
            cnt_raddr = r_elem_rd;
        end else begin
            cnt_re = 1'b0;
        end

        cnt_we    = 1'b0;
        cnt_waddr = r_bucket;
        cnt_wdata = cnt_eff + CW'(1);
        priority if (i_cmd.load_commit) begin
            cnt_we = room;
        end else if (i_cmd.scan_write) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_scan_idx;
            cnt_wdata = r_sum;
        end else if (i_cmd.elem_emit) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_elem_rd;
        end else begin
            cnt_we = 1'b0;
        end
    end

    assign elem_we = i_cmd.load_commit && room;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= cnt_mem[cnt_raddr];
            r_rd_vld <= clr ? 1'b0 : r_cnt_vld[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[r_total[EAW-1:0]] <= r_bucket;
        end
        if (i_cmd.elem_read) begin
            r_elem_rd <= elem_mem[r_drain[EAW-1:0]];
        end
    end

    // set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_bits <= RADIX_BITS_RST;
            r_shift      <= SHIFT_RST;
            r_act_bits   <= '0;
            r_phase      <= PH_LOAD;
            r_total      <= '0;
            r_ovf        <= 1'b0;
            r_drain      <= '0;
            r_cnt_vld    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RADIX_BITS:   r_radix_bits <= i_cfg_data[RADIX_BITS_W-1:0];
                    REG_SHIFT_AMOUNT: r_shift      <= i_cfg_data[SHIFT_W-1:0];
                endcase
            end

            // held until taken; a new result loads only into a free register
            r_out_valid <= i_cmd.bkt_emit || i_cmd.elem_emit || (r_out_valid && !i_out_ready);

            // a load after the set closed starts a new set
            if (clr) begin
                r_cnt_vld <= '0;
                r_total   <= '0;
                r_ovf     <= 1'b0;
                r_drain   <= '0;
                r_phase   <= PH_LOAD;
            end
            if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end

            if (i_cmd.load_commit) begin
                if (room) begin
                    r_total <= r_total + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.scan_write && (&r_scan_idx)) begin
                r_phase    <= PH_BUCKETS;
                r_act_bits <= act_bits;
                r_drain    <= '0;
            end

            if (i_cmd.bkt_emit) begin
                if (bkt_last) begin
                    r_drain <= '0;
                    r_phase <= (r_total == '0) ? PH_DONE : PH_ELEMENTS;
                end else begin
                    r_drain <= r_drain + DW'(1);
                end
            end

            if (i_cmd.elem_emit) begin
                r_drain <= r_drain + DW'(1);
                if (elem_last) begin
                    r_phase <= PH_DONE;
                end
            end

            if (i_cmd.elem_skip) begin
                r_phase <= PH_DONE;
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_bucket <= in_bucket;
            r_fin    <= i_final_load;
        end
        if (i_cmd.load_commit && r_fin) begin
            r_scan_idx <= '0;
            r_sum      <= '0;
        end
        if (i_cmd.scan_write) begin
            r_scan_idx <= r_scan_idx + BUCKET_BITS'(1);
            r_sum      <= r_sum + cnt_eff;
        end
        if (i_cmd.bkt_emit) begin
            r_out_kind <= KIND_BUCKET;
            r_out_idx  <= drain_ext[ITEM_IDX_W-1:0];
            r_out_pos  <= cnt_ext[POS_W-1:0];
            r_out_fin  <= bkt_last && (r_total == '0);
            r_out_ovf  <= r_ovf;
        end
        if (i_cmd.elem_emit) begin
            r_out_kind <= KIND_ELEMENT;
            r_out_idx  <= drain_ext[ITEM_IDX_W-1:0];
            r_out_pos  <= cnt_ext[POS_W-1:0];
            r_out_fin  <= elem_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_stat.phase        = r_phase;
    assign o_stat.fin          = r_fin;
    assign o_stat.scan_last    = &r_scan_idx;
    assign o_stat.elem_pending = (drain_ext < 32'(r_total)) && (drain_ext < MAX_ELEMENTS);
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_item_index   = r_out_idx;
    assign o_position     = r_out_pos;
    assign o_final_result = r_out_fin;
    assign o_overflowed   = r_out_ovf;

endmodule

`default_nettype wire

// File: rtl/radix_partition_positions_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Carries                                              Moves when
// i_item    in   opcode, value, final_load                            valid && ready
// o_result  out  kind, item_index, position, final_result, overflowed valid && ready
// i_cfg_*   in   register index, write data                           i_cfg_we
//
// A load reads the bucket's count, then writes the count and the element store.
// A final load adds the prefix-sum walk: a count read, then a running-sum write, per bucket.
// A bucket-start request reads the count, then presents it; an element request does an
// element store read, count read, then count write-back; both follow the registered store reads.
// Reset is synchronous; histogram entries carry valid bits, so no clearing pass.
// A result waits in the output register; a full register only stalls the next
// request that produces a transfer.

module radix_partition_positions_unit #(
    parameter int MAX_ELEMENTS = rpp_pkg::MAX_ELEMENTS_DEF,
    parameter int BUCKET_BITS  = rpp_pkg::BUCKET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rpp_item_if.sink                            i_item,
    rpp_result_if.source                        o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer: one item at a time
    rpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_opcode   (i_item.opcode),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_item.ready = in_ready;

    // histogram, element store, drain counters and output register
    rpp_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .BUCKET_BITS  (BUCKET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_value        (i_item.value),
        .i_final_load   (i_item.final_load),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_kind         (o_result.kind),
        .o_item_index   (o_result.item_index),
        .o_position     (o_result.position),
        .o_final_result (o_result.final_result),
        .o_overflowed   (o_result.overflowed),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

`default_nettype wire

// File: tb/tb_radix_partition_positions_unit.sv
`timescale 1ns / 1ps

module tb_radix_partition_positions_unit;
    import rpp_pkg::*;

    localparam int MAX_ELEM      = MAX_ELEMENTS_DEF;
    localparam int BKT_BITS      = BUCKET_BITS_DEF;
    localparam int NUM_BKT       = 1 << BKT_BITS;
    // prefix walk reads and writes every bucket; margin on top
    localparam int SETTLE_CYCLES = 2 * NUM_BKT + 40;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 450;   // per idling phase, four phases

    // One position transfer as seen on the result channel
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [ITEM_IDX_W-1:0] item_index;
        logic [POS_W-1:0]      position;
        logic                  final_result;
        logic                  overflowed;
    } t_position;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rpp_item_if   item_ch ();
    rpp_result_if result_ch ();

    radix_partition_positions_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Partition state mirror: registers, per-element buckets, histogram
    // (turned into running start slots at the final load), drain cursor.
    // ------------------------------------------------------------------
    logic [RADIX_BITS_W-1:0] radix_bits_cfg;
    logic [SHIFT_W-1:0]      shift_cfg;
    logic [BKT_BITS-1:0]     elem_bucket [MAX_ELEM];
    logic [POS_W-1:0]        bucket_slot [NUM_BKT];
    logic [POS_W-1:0]        elem_count;
    t_phase                  set_phase;
    logic [POS_W-1:0]        drain_ptr;
    logic                    dropped_any;
    logic [BKT_BITS:0]       open_buckets;   // bucket count latched at final load

    t_position pending_positions [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int stall_hold_req = 0;   // long receiver hold-off, picked up by the sink process
    int errors         = 0;
    int useful_items   = 0;   // loads plus requests that yield a transfer
    int loads_sent     = 0;
    int positions_seen = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    // radix_bits - 1, floored at 0 and saturated at the bucket width
    function automatic int active_bucket_bits();
        int b;
        b = (radix_bits_cfg == 0) ? 0 : int'(radix_bits_cfg) - 1;
        return (b > BKT_BITS) ? BKT_BITS : b;
    endfunction

    function automatic void open_new_set();
        foreach (bucket_slot[i]) bucket_slot[i] = '0;
        elem_count  = '0;
        dropped_any = 1'b0;
        drain_ptr   = '0;
        set_phase   = PH_LOAD;
    endfunction

    // Applies one accepted item; returns 1 with the position it yields, if any
    function automatic bit partition_position(input logic [OPCODE_W-1:0] op,
                                              input logic signed [VALUE_W-1:0] val,
                                              input logic fin, output t_position rec);
        logic signed [VALUE_W-1:0] shifted;
        logic [BKT_BITS-1:0]       mask;
        logic [BKT_BITS-1:0]       bkt;
        logic                      last_one;
        int                        sum;
        int                        cnt;
        rec = '0;
        if (op == OP_LOAD) begin
            // a load on a closed set throws the old set away
            if (set_phase != PH_LOAD) open_new_set();
            if (elem_count < MAX_ELEM) begin
                shifted = val >>> shift_cfg;
                mask    = BKT_BITS'((1 << active_bucket_bits()) - 1);
                bkt     = shifted[BKT_BITS-1:0] & mask;
                elem_bucket[elem_count[ITEM_IDX_W-1:0]] = bkt;
                bucket_slot[bkt] = bucket_slot[bkt] + 1'b1;
                elem_count       = elem_count + 1'b1;
            end else begin
                dropped_any = 1'b1;   // still honors the final mark below
            end
            if (fin) begin
                // exclusive prefix sum over every bucket, not just the active ones
                sum = 0;
                for (int i = 0; i < NUM_BKT; i++) begin
                    cnt            = int'(bucket_slot[i]);
                    bucket_slot[i] = POS_W'(sum);
                    sum           += cnt;
                end
                open_buckets = (BKT_BITS + 1)'(1 << active_bucket_bits());
                drain_ptr    = '0;
                set_phase    = PH_BUCKETS;
            end
            return 1'b0;
        end
        if (set_phase == PH_BUCKETS) begin
            last_one          = (drain_ptr + 1 >= open_buckets);
            rec.kind          = KIND_BUCKET;
            rec.item_index    = drain_ptr[ITEM_IDX_W-1:0];
            rec.position      = bucket_slot[drain_ptr[BKT_BITS-1:0]];
            rec.final_result  = last_one && (elem_count == 0);
            rec.overflowed    = dropped_any;
            drain_ptr         = drain_ptr + 1'b1;
            if (last_one) begin
                drain_ptr = '0;
                set_phase = (elem_count == 0) ? PH_DONE : PH_ELEMENTS;
            end
            return 1'b1;
        end
        if (set_phase == PH_ELEMENTS) begin
            if (drain_ptr >= elem_count) begin
                set_phase = PH_DONE;
                return 1'b0;
            end
            bkt              = elem_bucket[drain_ptr[ITEM_IDX_W-1:0]];
            last_one         = (drain_ptr + 1 >= elem_count);
            rec.kind         = KIND_ELEMENT;
            rec.item_index   = drain_ptr[ITEM_IDX_W-1:0];
            rec.position     = bucket_slot[bkt];
            rec.final_result = last_one;
            rec.overflowed   = dropped_any;
            bucket_slot[bkt] = bucket_slot[bkt] + 1'b1;
            drain_ptr        = drain_ptr + 1'b1;
            if (last_one) set_phase = PH_DONE;
            return 1'b1;
        end
        // request while loading or after the last position
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. Every task is entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offers one item with random leading idle cycles; returns at the transfer edge
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic signed [VALUE_W-1:0] val, input logic fin);
        t_position rec;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= op;
        item_ch.value      <= val;
        item_ch.final_load <= fin;
        do @(posedge i_clk); while (!item_ch.ready);
        if (partition_position(op, val, fin, rec)) begin
            pending_positions.push_back(rec);
            useful_items++;
        end else if (op == OP_LOAD) begin
            useful_items++;
        end
        if (op == OP_LOAD) loads_sent++;
    endtask

    // Requests carry a random final mark, which the block ignores
    task automatic send_requests(input int count);
        repeat (count) send_item(OP_REQUEST, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Quiet the input, let every expected transfer land, then cover a prefix walk
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_RADIX_BITS) radix_bits_cfg = data[RADIX_BITS_W-1:0];
        else shift_cfg = data[SHIFT_W-1:0];
        reg_writes++;
    endtask

    task automatic set_partition(input logic [RADIX_BITS_W-1:0] radix,
                                 input logic [SHIFT_W-1:0] shamt);
        wait_idle();
        write_reg(REG_RADIX_BITS, {1'b0, radix});
        write_reg(REG_SHIFT_AMOUNT, shamt);
    endtask

    // Mostly few buckets to keep drains short; now and then the full or saturated width
    task automatic pick_partition();
        int                      sel;
        logic                    pad;
        logic [RADIX_BITS_W-1:0] radix;
        logic [SHIFT_W-1:0]      shamt;
        sel = $urandom_range(0, 99);
        if (sel < 80)      radix = RADIX_BITS_W'($urandom_range(0, 4));
        else if (sel < 92) radix = RADIX_BITS_W'($urandom_range(5, 8));
        else               radix = RADIX_BITS_W'($urandom_range(9, 15));
        case ($urandom_range(0, 3))
            0:       shamt = '0;
            1:       shamt = '1;
            default: shamt = SHIFT_W'($urandom);
        endcase
        pad = 1'($urandom_range(0, 1));   // upper data bit is ignored by the radix register
        wait_idle();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_RADIX_BITS, {pad, radix});
            write_reg(REG_SHIFT_AMOUNT, shamt);
        end else begin
            write_reg(REG_SHIFT_AMOUNT, shamt);
            write_reg(REG_RADIX_BITS, {pad, radix});
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (8 bucket bits, no shift): first bucket starts only,
    // set left half drained so the next load abandons it
    task automatic test_reset_defaults();
        send_item(OP_LOAD, 32'sh0000_0080, 1'b0);
        send_item(OP_LOAD, 32'sh0000_0001, 1'b0);
        send_item(OP_LOAD, 32'shFFFF_FF02, 1'b1);
        send_requests(4);
    endtask

    // Sign extremes under the widest shift, request while loading,
    // request past the last position
    task automatic test_field_extremes();
        set_partition(4'd3, 5'd31);
        send_item(OP_LOAD, 32'sh8000_0000, 1'b0);
        send_item(OP_LOAD, 32'sh7FFF_FFFF, 1'b0);
        send_item(OP_REQUEST, 32'sh7FFF_FFFF, 1'b1);
        send_item(OP_LOAD, -32'sd1, 1'b0);
        send_item(OP_LOAD, 32'sd0, 1'b1);
        repeat (8) send_item(OP_REQUEST, $urandom, 1'b1);
        send_item(OP_REQUEST, 32'sd0, 1'b0);
    endtask

    // Saturated radix setting, then a narrower one mid set: old elements
    // keep their wide buckets, the emitted bucket count follows the final load
    task automatic test_saturation_mid_set();
        set_partition(4'd15, 5'd0);
        send_item(OP_LOAD, 32'sh1234_5677, 1'b0);
        send_item(OP_LOAD, -32'sd1, 1'b0);
        set_partition(4'd3, 5'd1);
        send_item(OP_LOAD, 32'sh0000_0006, 1'b1);
        send_requests(4 + 3);
    endtask

    // Receiver holds off far longer than the prefix walk; sender keeps offering
    task automatic test_output_stall();
        set_partition(4'd0, 5'd7);
        stall_hold_req = 1500;
        for (int i = 0; i < 6; i++) send_item(OP_LOAD, $urandom, i == 5);
        send_requests(1 + 6);
    endtask

    // Fill to capacity in bucket 0, drop two more (final mark on a dropped load);
    // bucket 1 starts at the full count and the leading element positions carry
    // the flag; the next load abandons the rest of the drain
    task automatic test_capacity_overflow();
        logic signed [VALUE_W-1:0] val;
        set_partition(4'd2, 5'd0);
        for (int i = 0; i < MAX_ELEM + 2; i++) begin
            val    = $urandom;
            val[0] = 1'b0;
            send_item(OP_LOAD, val, i == MAX_ELEM + 1);
        end
        send_requests(2 + 8);
    endtask

    // Well-formed sets with random content, plus noise: stray requests while
    // loading, a missing final mark, abandoned drains, requests after the end
    task automatic test_random_sets(input int idle_pct, input int stall_pct);
        int                        start_items;
        int                        n;
        int                        req;
        logic                      fin;
        logic signed [VALUE_W-1:0] val;
        wait_idle();
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start_items    = useful_items;
        while (useful_items - start_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) pick_partition();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) send_requests(1);
                if (i == n / 2 && $urandom_range(0, 19) == 0) pick_partition();
                val = $urandom;
                if ($urandom_range(0, 3) == 0) val = val >>> $urandom_range(8, 31);
                fin = (i == n - 1) && ($urandom_range(0, 19) != 0);
                send_item(OP_LOAD, val, fin);
            end
            req = int'(open_buckets) + n;
            case ($urandom_range(0, 19))
                0, 1, 2: req = $urandom_range(0, req - 1);
                3, 4:    req = req + $urandom_range(1, 3);
                default: ;
            endcase
            send_requests(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, long hold-off on request, in-order check
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin : result_check
        t_position got;
        t_position want;
        int        hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (result_ch.valid && result_ch.ready) begin
                    got = '{result_ch.kind, result_ch.item_index, result_ch.position,
                            result_ch.final_result, result_ch.overflowed};
                    positions_seen++;
                    if (pending_positions.size() == 0) begin
                        $display("%0t: position transfer with none expected: kind %0d index %0d pos %0d",
                                 $time, got.kind, got.item_index, got.position);
                        errors++;
                    end else begin
                        want = pending_positions.pop_front();
                        check_field("kind", 32'(want.kind), 32'(got.kind));
                        check_field("item_index", 32'(want.item_index), 32'(got.item_index));
                        check_field("position", 32'(want.position), 32'(got.position));
                        check_field("final_result", 32'(want.final_result),
                                    32'(got.final_result));
                        check_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
                    end
                end
                if (stall_hold_req != 0) begin
                    hold_left      = stall_hold_req;
                    stall_hold_req = 0;
                end
                if (hold_left != 0) begin
                    result_ch.ready <= 1'b0;
                    hold_left--;
                end else begin
                    result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d transfers outstanding",
                     cycle_count, pending_positions.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.opcode     <= OP_LOAD;
        item_ch.value      <= '0;
        item_ch.final_load <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_RADIX_BITS;
        cfg_data           <= '0;

        radix_bits_cfg = RADIX_BITS_RST;
        shift_cfg      = SHIFT_RST;
        open_new_set();
        open_buckets   = 1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_saturation_mid_set();
        test_output_stall();
        test_capacity_overflow();
        test_random_sets(0, 0);
        test_random_sets(81, 0);
        test_random_sets(0, 81);
        test_random_sets(7, 7);

        // drain: everything in flight, then a quiet tail for stray transfers
        item_ch.valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads and checked %0d position transfers across %0d register writes,",
                 loads_sent, positions_seen, reg_writes);
        $display("with a capacity overflow set, mid-set setting changes and a long output hold-off");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
